### rtl/core/adjoint_stencil_quadrature_macros.svh
// Assertion macros shared by the adjoint stencil quadrature RTL.
// Needs clk_i and rst_ni in the scope of the module that uses ASQ_ASSERT.
`ifndef ADJOINT_STENCIL_QUADRATURE_MACROS_SVH
`define ADJOINT_STENCIL_QUADRATURE_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset
`define ASQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset
`define ASQ_ASSERT(lbl, prop, msg) \
  `ASQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/asq_pkg.sv
// Package for the adjoint stencil quadrature block: widths, register
// indices, reset values, controller types and the output saturation helper.
package asq_pkg;

  localparam int ValueBits = 32;
  localparam int CoefW     = 31;
  localparam int IdxW      = 10;
  localparam int CfgIdxW   = 3;
  localparam int InW       = 2 * ValueBits;
  localparam int OutPad    = 6;
  localparam int OutW      = IdxW + 3 * ValueBits + OutPad;

  localparam int MulAW = 64;
  localparam int MulBW = 32;
  localparam int T1W   = 49;
  localparam int ZW    = 48;
  localparam int SumW  = 62;

  localparam logic signed [SumW-1:0] SumLim = 62'sh1000000000000000;

  localparam logic [CfgIdxW-1:0] RegDiffCoef = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAdvCoef  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInvDxSq  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInvTwoDx = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGridStep = 3'd4;

  localparam logic [CoefW-1:0] DiffCoefRst = 31'd7225344;
  localparam logic [CoefW-1:0] AdvCoefRst  = 31'd172032;
  localparam logic [CoefW-1:0] InvDxSqRst  = 31'd7225344;
  localparam logic [CoefW-1:0] InvTwoDxRst = 31'd344064;
  localparam logic [CoefW-1:0] GridStepRst = 31'd6242;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GO,
    ST_WAIT,
    ST_ACC,
    ST_EMIT,
    ST_SHIFT,
    ST_CLEAR
  } asq_state_e;

  typedef enum logic [2:0] {
    OP_DIFF,
    OP_ADV,
    OP_GRAD2,
    OP_GRAD1,
    OP_ZDIFF,
    OP_ZADV,
    OP_INT_DIFF,
    OP_INT_ADV
  } asq_op_e;

  typedef struct packed {
    logic    capture;
    logic    shift;
    logic    clear;
    logic    accum;
    logic    mul_start;
    logic    store;
    logic    emit;
    logic    emit_last;
    asq_op_e op;
  } asq_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
    logic cnt_nz;
    logic last;
  } asq_sts_t;

  function automatic logic signed [ValueBits-1:0] sat_val(input logic signed [MulAW-1:0] x);
    logic signed [ValueBits-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[ValueBits-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/asq_mul.sv
// Iterative signed multiplier with rounding shift, 16-bit digit per cycle.
// Depends on asq_pkg and the assertion macro header.
`include "adjoint_stencil_quadrature_macros.svh"

module asq_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [asq_pkg::MulAW-1:0]   a_i,
  input  logic signed [asq_pkg::MulBW-1:0]   b_i,
  input  logic                               sh17_i,
  output logic                               done_o,
  output logic signed [asq_pkg::MulAW-1:0]   res_o
);
  import asq_pkg::*;

  localparam int AccW = MulAW + MulBW;
  localparam int DigW = 16;
  localparam int NDig = MulAW / DigW;
  localparam int MagW = 63;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StAbs      = 3'd1;
  localparam logic [2:0] StMulFirst = 3'd2;
  localparam logic [2:0] StMulLast  = 3'(StMulFirst + NDig - 1);
  localparam logic [2:0] StRound    = 3'(StMulLast + 1);
  localparam logic [2:0] StSign     = 3'(StRound + 1);

  localparam logic [AccW:0] MagCap = (AccW+1)'(1) << (MagW - 1);

  logic [2:0]           step_q, step_d;
  logic                 done_q;
  logic [MulAW-1:0]     a_q;
  logic [MulBW-1:0]     b_q;
  logic                 neg_q;
  logic                 sh17_q;
  logic [AccW-1:0]      acc_q;
  logic [MagW-1:0]      mag_q;
  logic [MulAW-1:0]     res_q;

  logic [MulBW+DigW-1:0] pp;
  logic [AccW:0]         rnd_sum;
  logic [AccW:0]         rnd_shift;
  logic [MagW-1:0]       mag_d;

  always_comb begin
    pp        = a_q[MulAW-1 -: DigW] * b_q;
    rnd_sum   = (AccW+1)'(acc_q) + ((AccW+1)'(1) << (sh17_q ? 16 : 15));
    rnd_shift = rnd_sum >> (sh17_q ? 17 : 16);
    if (rnd_shift > MagCap) begin
      mag_d = MagCap[MagW-1:0];
    end else begin
      mag_d = rnd_shift[MagW-1:0];
    end
  end

  always_comb begin
    step_d = step_q;
    case (step_q)
      StIdle: if (start_i) step_d = StAbs;
      StSign: step_d = StIdle;
      default: step_d = step_q + 3'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == StSign);
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q) inside
      StIdle: begin
        if (start_i) begin
          a_q    <= a_i;
          b_q    <= b_i;
          sh17_q <= sh17_i;
        end
      end
      StAbs: begin
        neg_q <= a_q[MulAW-1] ^ b_q[MulBW-1];
        a_q   <= a_q[MulAW-1] ? -a_q : a_q;
        b_q   <= b_q[MulBW-1] ? -b_q : b_q;
        acc_q <= '0;
      end
      [StMulFirst:StMulLast]: begin
        acc_q <= {acc_q[AccW-DigW-1:0], {DigW{1'b0}}} + AccW'(pp);
        a_q   <= a_q << DigW;
      end
      StRound: mag_q <= mag_d;
      StSign:  res_q <= neg_q ? -MulAW'(mag_q) : MulAW'(mag_q);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ASQ_ASSERT(a_mul_start_idle, start_i |-> (step_q == StIdle), "multiply started while busy")
  `ASQ_ASSERT(a_mul_done_after_sign, done_q |-> $past(step_q == StSign), "done without sign step")
  `ASQ_ASSERT(a_mul_done_pulse, done_q |=> !done_q, "done held longer than a cycle")

endmodule

### rtl/core/asq_dpath.sv
// Datapath: config registers, three-point window, shared multiplier,
// quadrature sums and output word register. Depends on asq_pkg, asq_mul.
module asq_dpath #(
  parameter int MaxPoints = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  asq_pkg::asq_cmd_t               cmd_i,
  output asq_pkg::asq_sts_t               sts_o,
  input  logic                            cfg_valid_i,
  input  logic [asq_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [asq_pkg::CoefW-1:0]       cfg_data_i,
  input  logic [asq_pkg::InW-1:0]         s_tdata_i,
  input  logic                            s_tlast_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [asq_pkg::OutW-1:0]        m_tdata_o,
  output logic                            m_tlast_o
);
  import asq_pkg::*;

  localparam int CntW = $clog2(MaxPoints + 1);

  logic [CoefW-1:0] diff_q, adv_q, idsq_q, i2dx_q, step_q;

  logic signed [ValueBits-1:0] ul_q, uc_q, ur_q, vl_q, vc_q, vr_q;
  logic [CntW-1:0]             cnt_q;
  logic                        last_q, single_q;
  logic signed [SumW-1:0]      sumd_q, suma_q;
  logic signed [ZW-1:0]        firstd_q, firsta_q;

  logic signed [T1W-1:0]       t1_q;
  logic signed [ValueBits-1:0] rate_q, g1_q, g2_q, intd_q, inta_q;
  logic signed [ZW-1:0]        zd_q, za_q;

  logic                        m_valid_q, m_last_q;
  logic [IdxW-1:0]             m_idx_q;
  logic [ValueBits-1:0]        m_rate_q, m_intd_q, m_inta_q;

  logic signed [33:0]          d2u, d2v;
  logic signed [32:0]          du, dv;
  logic signed [MulAW-1:0]     td, ta;
  logic signed [MulAW-1:0]     mul_a;
  logic signed [MulBW-1:0]     mul_b;
  logic                        mul_sh17;
  logic                        mul_done;
  logic signed [MulAW-1:0]     mul_res;
  logic [CntW-1:0]             idx;
  logic [CntW+IdxW-1:0]        idx_ext;
  logic                        out_free;

  function automatic logic signed [SumW-1:0] clamp_sum(input logic signed [SumW-1:0] s,
                                                       input logic signed [ZW-1:0] z);
    logic signed [SumW:0] t;
    logic signed [SumW-1:0] r;
    t = (SumW+1)'(s) + (SumW+1)'(z);
    if (t > (SumW+1)'(SumLim)) begin
      r = SumLim;
    end else if (t < -(SumW+1)'(SumLim)) begin
      r = -SumLim;
    end else begin
      r = t[SumW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    d2u = 34'(ul_q) - (34'(uc_q) <<< 1) + 34'(ur_q);
    d2v = 34'(vl_q) - (34'(vc_q) <<< 1) + 34'(vr_q);
    du  = 33'(ur_q) - 33'(ul_q);
    dv  = 33'(vr_q) - 33'(vl_q);
    if (single_q) begin
      td = 64'(firstd_q) <<< 1;
      ta = 64'(firsta_q) <<< 1;
    end else begin
      td = (64'(sumd_q) <<< 1) - 64'(firstd_q) - 64'(zd_q);
      ta = (64'(suma_q) <<< 1) - 64'(firsta_q) - 64'(za_q);
    end
  end

  always_comb begin
    mul_sh17 = 1'b0;
    case (cmd_i.op)
      OP_DIFF: begin
        mul_a = 64'(d2v);
        mul_b = {1'b0, diff_q};
      end
      OP_ADV: begin
        mul_a = 64'(dv);
        mul_b = {1'b0, adv_q};
      end
      OP_GRAD2: begin
        mul_a = 64'(d2u);
        mul_b = {1'b0, idsq_q};
      end
      OP_GRAD1: begin
        mul_a = 64'(du);
        mul_b = {1'b0, i2dx_q};
      end
      OP_ZDIFF: begin
        mul_a = 64'(vc_q);
        mul_b = g1_q;
      end
      OP_ZADV: begin
        mul_a = 64'(vc_q);
        mul_b = g2_q;
      end
      OP_INT_DIFF: begin
        mul_a    = td;
        mul_b    = {1'b0, step_q};
        mul_sh17 = 1'b1;
      end
      OP_INT_ADV: begin
        mul_a    = ta;
        mul_b    = {1'b0, step_q};
        mul_sh17 = 1'b1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  asq_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh17_i  (mul_sh17),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= DiffCoefRst;
      adv_q  <= AdvCoefRst;
      idsq_q <= InvDxSqRst;
      i2dx_q <= InvTwoDxRst;
      step_q <= GridStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDiffCoef: diff_q <= cfg_data_i;
        RegAdvCoef:  adv_q  <= cfg_data_i;
        RegInvDxSq:  idsq_q <= cfg_data_i;
        RegInvTwoDx: i2dx_q <= cfg_data_i;
        RegGridStep: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q     <= '0;
      uc_q     <= '0;
      ur_q     <= '0;
      vl_q     <= '0;
      vc_q     <= '0;
      vr_q     <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      single_q <= 1'b0;
      sumd_q   <= '0;
      suma_q   <= '0;
      firstd_q <= '0;
      firsta_q <= '0;
    end else if (cmd_i.clear) begin
      ul_q     <= '0;
      uc_q     <= '0;
      ur_q     <= '0;
      vl_q     <= '0;
      vc_q     <= '0;
      vr_q     <= '0;
      cnt_q    <= '0;
      sumd_q   <= '0;
      suma_q   <= '0;
      firstd_q <= '0;
      firsta_q <= '0;
    end else if (cmd_i.capture) begin
      ur_q     <= s_tdata_i[ValueBits-1:0];
      vr_q     <= s_tdata_i[InW-1:ValueBits];
      last_q   <= s_tlast_i;
      single_q <= (cnt_q == '0);
    end else if (cmd_i.shift) begin
      ul_q <= uc_q;
      uc_q <= ur_q;
      ur_q <= '0;
      vl_q <= vc_q;
      vc_q <= vr_q;
      vr_q <= '0;
      if (cnt_q != CntW'(MaxPoints)) cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.accum) begin
      sumd_q <= clamp_sum(sumd_q, zd_q);
      suma_q <= clamp_sum(suma_q, za_q);
      if (cnt_q == CntW'(1)) begin
        firstd_q <= zd_q;
        firsta_q <= za_q;
      end
    end
  end

  // multiplier results
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      case (cmd_i.op)
        OP_DIFF:     t1_q   <= mul_res[T1W-1:0];
        OP_ADV:      rate_q <= sat_val(mul_res - 64'(t1_q));
        OP_GRAD2:    g1_q   <= sat_val(mul_res);
        OP_GRAD1:    g2_q   <= sat_val(mul_res);
        OP_ZDIFF:    zd_q   <= mul_res[ZW-1:0];
        OP_ZADV:     za_q   <= mul_res[ZW-1:0];
        OP_INT_DIFF: intd_q <= sat_val(mul_res);
        OP_INT_ADV:  inta_q <= sat_val(mul_res);
        default: ;
      endcase
    end
  end

  // output word register
  assign out_free = !m_valid_q || m_tready_i;
  assign idx      = cnt_q - CntW'(1);
  assign idx_ext  = {IdxW'(0), idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_idx_q  <= idx_ext[IdxW-1:0];
      m_rate_q <= rate_q;
      m_intd_q <= cmd_i.emit_last ? intd_q : '0;
      m_inta_q <= cmd_i.emit_last ? inta_q : '0;
      m_last_q <= cmd_i.emit_last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{OutPad{1'b0}}, m_inta_q, m_intd_q, m_rate_q, m_idx_q};
  assign m_tlast_o  = m_last_q;

  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = out_free;
  assign sts_o.cnt_nz   = (cnt_q != '0);
  assign sts_o.last     = last_q;

endmodule

### rtl/core/asq_ctrl.sv
// Controller: sequences capture, the six stencil multiplies, the two
// integral multiplies, accumulation and output. Depends on asq_pkg and the assertion macro header.
`include "adjoint_stencil_quadrature_macros.svh"

module asq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  asq_pkg::asq_sts_t  sts_i,
  output asq_pkg::asq_cmd_t  cmd_o
);
  import asq_pkg::*;

  asq_state_e state_q, state_d;
  asq_op_e    op_q, op_d, op_next;
  logic       pass2_q, pass2_d;

  always_comb begin
    case (op_q)
      OP_DIFF:     op_next = OP_ADV;
      OP_ADV:      op_next = OP_GRAD2;
      OP_GRAD2:    op_next = OP_GRAD1;
      OP_GRAD1:    op_next = OP_ZDIFF;
      OP_ZDIFF:    op_next = OP_ZADV;
      OP_INT_DIFF: op_next = OP_INT_ADV;
      default:     op_next = OP_DIFF;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    pass2_d = pass2_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          pass2_d = 1'b0;
          op_d    = OP_DIFF;
          state_d = sts_i.cnt_nz ? ST_GO : ST_SHIFT;
        end
      end
      ST_GO: state_d = ST_WAIT;
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          case (op_q)
            OP_ZADV:    state_d = ST_ACC;
            OP_INT_ADV: state_d = ST_EMIT;
            default: begin
              op_d    = op_next;
              state_d = ST_GO;
            end
          endcase
        end
      end
      ST_ACC: begin
        if (pass2_q) begin
          op_d    = OP_INT_DIFF;
          state_d = ST_GO;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = pass2_q ? ST_CLEAR : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts_i.last) begin
          pass2_d = 1'b1;
          op_d    = OP_DIFF;
          state_d = ST_GO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.emit_last = pass2_q;
    s_tready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
      end
      ST_GO:    cmd_o.mul_start = 1'b1;
      ST_WAIT:  cmd_o.store     = sts_i.mul_done;
      ST_ACC:   cmd_o.accum     = 1'b1;
      ST_EMIT:  cmd_o.emit      = sts_i.out_free;
      ST_SHIFT: cmd_o.shift     = 1'b1;
      ST_CLEAR: cmd_o.clear     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DIFF;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pass2_q <= pass2_d;
    end
  end

  `ASQ_ASSERT(a_ctrl_wait_holds, (state_q == ST_WAIT && !sts_i.mul_done) |=> (state_q == ST_WAIT), "left wait before multiply done")
  `ASQ_ASSERT(a_ctrl_last_clears, (cmd_o.emit && cmd_o.emit_last) |=> (state_q == ST_CLEAR), "run not cleared after final word")
  `ASQ_ASSERT(a_ctrl_int_follows, (state_q == ST_ACC && pass2_q) |=> (op_q == OP_INT_DIFF), "integral not started after final point")

endmodule

### rtl/core/adjoint_stencil_quadrature.sv
// Channel   Dir  Payload (low bit up)                                       Handshake
// s_axis    in   tdata: state_val[31:0] adj_val[63:32]; tlast: is_last       tvalid/tready
// m_axis    out  tdata: point_index, adj_rate, integ_diff, integ_adv; tlast  tvalid/tready
// cfg       in   cfg_index_i (register number), cfg_data_i (31-bit value)    cfg_valid_i/ready
// One shared iterative multiplier, six multiplies per point.
// A point that closes an earlier one runs that point's stencil; the first of a run is only taken in;
// a final point also runs its own stencil and the two integrals.
// Reset is asynchronous, active low; the config registers return to their default values.
// Input is taken only when the sequencer is idle; a held output word stalls at emit.
// Top level of the adjoint stencil quadrature block.
// Depends on asq_pkg, asq_ctrl, asq_dpath (asq_mul).
module adjoint_stencil_quadrature #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [asq_pkg::InW-1:0]       s_axis_tdata_i,  // state_val, adj_val
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // point_index, adj_rate, integral_diffusion, integral_advection, zero pad
  output logic [asq_pkg::OutW-1:0]      m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [asq_pkg::CoefW-1:0]     cfg_data_i
);
  import asq_pkg::*;

  asq_cmd_t cmd;
  asq_sts_t sts;

  assign cfg_ready_o = 1'b1;

  asq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asq_dpath #(
    .MaxPoints (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tlast_i   (s_axis_tlast_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

### verif/asq_result_checker.sv
// Checker for the adjoint stencil quadrature block: watches the point, rate word
// and register channels, predicts every rate word and compares it field by field.
// Depends on asq_pkg.
module asq_result_checker #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [asq_pkg::InW-1:0]     s_axis_tdata_i,  // state_val, adj_val
  input  logic                        s_axis_tlast_i,
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  // point_index, adj_rate, integral_diffusion, integral_advection, zero pad
  input  logic [asq_pkg::OutW-1:0]    m_axis_tdata_i,
  input  logic                        m_axis_tlast_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [asq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [asq_pkg::CoefW-1:0]   cfg_data_i,
  output int                          mismatch_cnt_o,
  output int                          words_due_o
);
  import asq_pkg::*;

  localparam longint Cap62   = 64'sh4000_0000_0000_0000;
  localparam longint ZLim    = 64'sh0100_0000_0000_0000;
  localparam longint SLim    = 64'sh1000_0000_0000_0000;
  localparam longint MulBLim = 64'sh0000_0000_FFFF_FFFF;
  localparam longint ValMax  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ValMin  = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [IdxW-1:0]      index;
    logic [ValueBits-1:0] rate;
    logic [ValueBits-1:0] int_diff;
    logic [ValueBits-1:0] int_adv;
    logic                 last;
  } rate_word_t;

  longint     diff_k, adv_k, lap_k, grad_k, dx_k;
  longint     u_hist[2], v_hist[2];
  int unsigned pts_taken;
  longint     acc_diff, acc_adv;
  longint     z_head[2];
  rate_word_t words_due[$];

  function automatic longint clamp_mag(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint sat_word(longint x);
    if (x > ValMax) return ValMax;
    if (x < ValMin) return ValMin;
    return x;
  endfunction

  // exact product, scaled down by 2^sh, rounded half away from zero
  function automatic longint fx_mul_round(longint a, longint b, int unsigned sh);
    logic [127:0]    prod;
    longint unsigned ma, mb;
    longint          r;
    logic            neg;
    neg = (a < 0) != (b < 0);
    a = clamp_mag(a, Cap62);
    b = clamp_mag(b, MulBLim);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (sh - 1))) >> sh;
    if (prod > {64'd0, Cap62}) prod = {64'd0, Cap62};
    r = prod[63:0];
    return neg ? -r : r;
  endfunction

  function automatic rate_word_t stencil_point(longint ul, longint uc, longint ur,
                                               longint vl, longint vc, longint vr,
                                               int unsigned idx,
                                               output longint zd, output longint za);
    rate_word_t w;
    longint     t_diff, t_adv, lap, grad, rate;
    t_diff = clamp_mag(fx_mul_round(vl - 2 * vc + vr, diff_k, 16), ZLim);
    t_adv  = clamp_mag(fx_mul_round(vr - vl, adv_k, 16), ZLim);
    lap    = sat_word(fx_mul_round(ul - 2 * uc + ur, lap_k, 16));
    grad   = sat_word(fx_mul_round(ur - ul, grad_k, 16));
    zd = clamp_mag(fx_mul_round(vc, lap, 16), ZLim);
    za = clamp_mag(fx_mul_round(vc, grad, 16), ZLim);
    acc_diff = clamp_mag(acc_diff + zd, SLim);
    acc_adv  = clamp_mag(acc_adv + za, SLim);
    if (idx == 0) begin
      z_head[0] = zd;
      z_head[1] = za;
    end
    rate = sat_word(t_adv - t_diff);
    w = '0;
    w.index = idx[IdxW-1:0];
    w.rate  = rate[ValueBits-1:0];
    return w;
  endfunction

  function automatic logic [ValueBits-1:0] trapezoid_integral(longint acc, longint z0,
                                                              longint zl, logic single);
    longint twice, r;
    twice = single ? 2 * z0 : 2 * acc - z0 - zl;
    r = sat_word(fx_mul_round(twice, dx_k, 17));
    return r[ValueBits-1:0];
  endfunction

  function automatic void clear_run();
    u_hist    = '{0, 0};
    v_hist    = '{0, 0};
    pts_taken = 0;
    acc_diff  = 0;
    acc_adv   = 0;
    z_head    = '{0, 0};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rate_word_t  w, got;
    longint      s, a, zd, za;
    int unsigned n;
    if (!rst_ni) begin
      diff_k = DiffCoefRst;
      adv_k  = AdvCoefRst;
      lap_k  = InvDxSqRst;
      grad_k = InvTwoDxRst;
      dx_k   = GridStepRst;
      clear_run();
      words_due.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegDiffCoef: diff_k = cfg_data_i;
          RegAdvCoef:  adv_k  = cfg_data_i;
          RegInvDxSq:  lap_k  = cfg_data_i;
          RegInvTwoDx: grad_k = cfg_data_i;
          RegGridStep: dx_k   = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        s = $signed(s_axis_tdata_i[ValueBits-1:0]);
        a = $signed(s_axis_tdata_i[InW-1:ValueBits]);
        n = pts_taken;
        // a new point closes the one before it
        if (n >= 1) begin
          w = stencil_point(n >= 2 ? u_hist[1] : 0, u_hist[0], s,
                            n >= 2 ? v_hist[1] : 0, v_hist[0], a, n - 1, zd, za);
          words_due.push_back(w);
        end
        u_hist[1] = u_hist[0];
        v_hist[1] = v_hist[0];
        u_hist[0] = s;
        v_hist[0] = a;
        if (n < MAX_POINTS) pts_taken = n + 1;
        if (s_axis_tlast_i) begin
          w = stencil_point(u_hist[1], s, 0, v_hist[1], a, 0, pts_taken - 1, zd, za);
          w.int_diff = trapezoid_integral(acc_diff, z_head[0], zd, n == 0);
          w.int_adv  = trapezoid_integral(acc_adv, z_head[1], za, n == 0);
          w.last     = 1'b1;
          words_due.push_back(w);
          clear_run();
        end
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.index    = m_axis_tdata_i[IdxW-1:0];
        got.rate     = m_axis_tdata_i[IdxW +: ValueBits];
        got.int_diff = m_axis_tdata_i[IdxW + ValueBits +: ValueBits];
        got.int_adv  = m_axis_tdata_i[IdxW + 2 * ValueBits +: ValueBits];
        got.last     = m_axis_tlast_i;
        if (words_due.size() == 0) begin
          $error("rate word with nothing predicted: point_index %0d", got.index);
          mismatch_cnt_o++;
        end else begin
          w = words_due.pop_front();
          if (got.index !== w.index) begin
            $error("point_index expected %0d actual %0d", w.index, got.index);
            mismatch_cnt_o++;
          end
          if (got.rate !== w.rate) begin
            $error("adj_rate expected %0d actual %0d", $signed(w.rate), $signed(got.rate));
            mismatch_cnt_o++;
          end
          if (got.int_diff !== w.int_diff) begin
            $error("integral_diffusion expected %0d actual %0d",
                   $signed(w.int_diff), $signed(got.int_diff));
            mismatch_cnt_o++;
          end
          if (got.int_adv !== w.int_adv) begin
            $error("integral_advection expected %0d actual %0d",
                   $signed(w.int_adv), $signed(got.int_adv));
            mismatch_cnt_o++;
          end
          if (got.last !== w.last) begin
            $error("last_of_run expected %0d actual %0d", w.last, got.last);
            mismatch_cnt_o++;
          end
        end
      end
    end
    words_due_o = words_due.size();
  end

endmodule

### verif/tb_adjoint_stencil_quadrature.sv
// Top of the adjoint stencil quadrature testbench: clock, reset, point and
// register stimulus, receiver stalls and the verdict.
// Depends on asq_pkg, adjoint_stencil_quadrature and asq_result_checker.
module tb_adjoint_stencil_quadrature;
  import asq_pkg::*;

  localparam int MaxPoints    = 1024;
  localparam int SettleCycles = 200;
  localparam int HoldCycles   = 500;
  localparam int RunLimit     = 2_400_000;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               pt_valid = 1'b0;
  logic               pt_ready;
  logic [InW-1:0]     pt_data  = '0;
  logic               pt_last  = 1'b0;
  logic               rate_valid;
  logic               rate_ready = 1'b0;
  logic [OutW-1:0]    rate_data;
  logic               rate_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoefW-1:0]   cfg_data  = '0;
  int                 mismatches;
  int                 words_due;
  int                 snd_idle  = 0;
  int                 rcv_stall = 0;
  logic               hold_req  = 1'b0;
  logic               hold_off  = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  adjoint_stencil_quadrature #(
    .MAX_POINTS(MaxPoints)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(pt_valid),
    .s_axis_tready_o(pt_ready),
    .s_axis_tdata_i (pt_data),
    .s_axis_tlast_i (pt_last),
    .m_axis_tvalid_o(rate_valid),
    .m_axis_tready_i(rate_ready),
    .m_axis_tdata_o (rate_data),
    .m_axis_tlast_o (rate_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  asq_result_checker #(
    .MAX_POINTS(MaxPoints)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(pt_valid),
    .s_axis_tready_i(pt_ready),
    .s_axis_tdata_i (pt_data),
    .s_axis_tlast_i (pt_last),
    .m_axis_tvalid_i(rate_valid),
    .m_axis_tready_i(rate_ready),
    .m_axis_tdata_i (rate_data),
    .m_axis_tlast_i (rate_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatches),
    .words_due_o    (words_due)
  );

  always @(negedge clk_i) begin
    rate_ready <= !hold_off && ($urandom_range(99) >= rcv_stall);
  end

  // long receiver hold-off, so the block backs up onto its input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #(RunLimit);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [ValueBits-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return CoefW'($urandom_range(1 << 20));
      default: return CoefW'($urandom);
    endcase
  endfunction

  task automatic send_point(logic [ValueBits-1:0] state_v, logic [ValueBits-1:0] adj_v,
                            logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      pt_valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_valid <= 1'b1;
    pt_data  <= {adj_v, state_v};
    pt_last  <= last;
    @(posedge clk_i);
    while (!pt_ready) @(posedge clk_i);
  endtask

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_point(pick_value(), pick_value(), i == len - 1);
  endtask

  task automatic random_runs(int points);
    int sent;
    int len;
    sent = 0;
    while (sent < points) begin
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = 2;
        2:       len = $urandom_range(20, 60);
        default: len = $urandom_range(3, 12);
      endcase
      send_run(len);
      sent += len;
    end
  endtask

  // all words in, then let a point that makes no word finish
  task automatic settle();
    @(negedge clk_i);
    pt_valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic write_all(logic [CoefW-1:0] diff, logic [CoefW-1:0] adv,
                           logic [CoefW-1:0] lap, logic [CoefW-1:0] grad,
                           logic [CoefW-1:0] step);
    write_reg(RegDiffCoef, diff);
    write_reg(RegAdvCoef, adv);
    write_reg(RegInvDxSq, lap);
    write_reg(RegInvTwoDx, grad);
    write_reg(RegGridStep, step);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: single points, short runs, extremes, zeros
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(32'h0001_0000, 32'h0002_0000, 1'b0);
    send_point(32'hFFFF_0000, 32'h0000_8000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point('0, '0, 1'b0);
    send_point('0, '0, 1'b1);
    for (int i = 0; i < 6; i++) send_point(i << 16, (3 - i) << 15, i == 5);
    settle();

    write_all('1, '1, '1, '1, '1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    random_runs(100);
    settle();

    write_all('0, '0, '0, '0, '0);
    snd_idle = 74;
    random_runs(100);
    settle();

    // unused register numbers must leave the coefficients alone
    for (int k = RegGridStep + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), CoefW'($urandom));
    end
    write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
    snd_idle  = 0;
    rcv_stall = 74;
    random_runs(120);
    settle();

    write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
    snd_idle  = 29;
    rcv_stall = 29;
    random_runs(120);
    settle();

    write_all(DiffCoefRst, AdvCoefRst, InvDxSqRst, InvTwoDxRst, GridStepRst);
    snd_idle  = 0;
    rcv_stall = 0;
    hold_req  = 1'b1;
    random_runs(160);
    settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
